@@ src/ihist_pkg.sv @@
// Shared types and constants for the intensity histogram.
package ihist_pkg;

	localparam int IDX_BITS = 8;
	localparam int OUT_BITS = 24;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_CNT_W = 3;

	localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

	typedef enum logic {
		CMD_COUNT = 1'b0,
		CMD_READ  = 1'b1
	} cmd_e;

	typedef struct packed {
		logic                cmd;
		logic [IDX_BITS-1:0] pixel_value;
		logic [IDX_BITS-1:0] bin_index;
	} hist_in_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] read_bin;
		logic [OUT_BITS-1:0] bin_count;
	} hist_out_t;

	typedef struct packed {
		logic                valid;
		logic                is_read;
		logic                in_range;
		logic [IDX_BITS-1:0] idx;
	} op_t;

	typedef struct packed {
		logic      valid;
		hist_out_t data;
	} res_push_t;

endpackage

@@ src/intensity_histogram_256.sv @@
// Intensity histogram: one request per cycle, set by the one-read one-write bin store pipeline.
// A read result moves from the front queue via the back-end s1 register to the result queue.
// Counts sustain one per cycle; reads sustain one per cycle while results are popped.
// Reset clears all bins at once through per-bin valid flags; no clearing pass is needed.
module intensity_histogram_256 #(
	parameter int NUM_BINS   = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  ihist_pkg::hist_in_t  in_data,
	output logic                 empty,
	input  logic                 pop,
	output ihist_pkg::hist_out_t out_data
);
	import ihist_pkg::*;

	op_t                 head;
	logic                head_pop;
	res_push_t           res;
	logic [OQ_CNT_W-1:0] res_cnt;

	ihist_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.head     (head),
		.head_pop (head_pop)
	);

	ihist_back #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_pop (head_pop),
		.res_cnt  (res_cnt),
		.res      (res)
	);

	ihist_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.cnt      (res_cnt),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

endmodule

@@ src/ihist_front.sv @@
// Front end: accepts requests, classifies them and holds them in a short queue.
module ihist_front #(
	parameter int NUM_BINS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  ihist_pkg::hist_in_t in_data,
	output ihist_pkg::op_t    head,
	input  logic              head_pop
);
	import ihist_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	op_t              ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	op_t              new_op;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign push_ok = push && !full;
	assign pop_ok  = head_pop && head.valid;

	always_comb begin
		new_op.valid    = 1'b1;
		new_op.is_read  = (in_data.cmd == CMD_READ);
		new_op.idx      = new_op.is_read ? in_data.bin_index : in_data.pixel_value;
		new_op.in_range = ({1'b0, new_op.idx} < (IDX_BITS + 1)'(NUM_BINS));
	end

	always_comb begin
		head       = ent_q[rd_ptr_q];
		head.valid = (cnt_q != '0);
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ent_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
		end
	end

endmodule

@@ src/ihist_back.sv @@
// Back end: read-modify-write of the bin store with forwarding between neighbors.
module ihist_back #(
	parameter int NUM_BINS   = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ihist_pkg::op_t               head,
	output logic                         head_pop,
	input  logic [ihist_pkg::OQ_CNT_W-1:0] res_cnt,
	output ihist_pkg::res_push_t         res
);
	import ihist_pkg::*;

	localparam int IDX_W = $clog2(NUM_BINS);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
	logic [NUM_BINS-1:0]   valid_q;

	logic                  v_s1;
	logic                  rd_s1;
	logic                  ok_s1;
	logic [IDX_W-1:0]      addr_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	logic [COUNT_BITS-1:0] rdata_s1;
	logic                  vld_s1;
	logic                  fwd_s1;
	logic [COUNT_BITS-1:0] fwd_val_s1;

	logic [IDX_W-1:0]      addr_head;
	logic [OQ_CNT_W:0]     occ;
	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] nxt;
	logic                  wr_en;
	logic [31:0]           cur32;

	assign addr_head = head.idx[IDX_W-1:0];

	// Reads reserve a result slot in the cycle before they push it.
	assign occ      = (OQ_CNT_W + 1)'(res_cnt) + (OQ_CNT_W + 1)'(v_s1 && rd_s1);
	assign head_pop = head.valid && (!head.is_read || (occ < (OQ_CNT_W + 1)'(OQ_DEPTH)));

	// The bin just written by the previous item was read before that write landed.
	assign cur   = fwd_s1 ? fwd_val_s1 : (vld_s1 ? rdata_s1 : '0);
	assign nxt   = rd_s1 ? '0 : ((cur == CNT_MAX) ? cur : cur + COUNT_BITS'(1));
	assign wr_en = v_s1 && ok_s1;
	assign cur32 = 32'(cur);

	always_comb begin
		res.valid         = v_s1 && rd_s1;
		res.data.read_bin = idx_s1;
		if (!ok_s1) begin
			res.data.bin_count = '0;
		end else if (cur32 > 32'(OUT_MAX)) begin
			res.data.bin_count = OUT_MAX;
		end else begin
			res.data.bin_count = cur32[OUT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			rdata_s1 <= mem_q[addr_head];
		end
		if (wr_en) begin
			mem_q[addr_s1] <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1      <= head.is_read;
		ok_s1      <= head.in_range;
		addr_s1    <= addr_head;
		idx_s1     <= head.idx;
		vld_s1     <= valid_q[addr_head];
		fwd_s1     <= wr_en && (addr_s1 == addr_head);
		fwd_val_s1 <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			valid_q <= '0;
		end else begin
			v_s1 <= head_pop;
			if (wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

@@ src/ihist_resq.sv @@
// Result queue between the back end and the consumer.
module ihist_resq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ihist_pkg::res_push_t           res,
	output logic [ihist_pkg::OQ_CNT_W-1:0] cnt,
	output logic                           empty,
	input  logic                           pop,
	output ihist_pkg::hist_out_t           out_data
);
	import ihist_pkg::*;

	localparam int PTR_W = $clog2(OQ_DEPTH);

	hist_out_t           ent_q [OQ_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [OQ_CNT_W-1:0] cnt_q;
	logic                pop_ok;

	assign cnt      = cnt_q;
	assign empty    = (cnt_q == '0);
	assign pop_ok   = pop && !empty;
	assign out_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res.valid) begin
			ent_q[wr_ptr_q] <= res.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res.valid) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + OQ_CNT_W'(res.valid) - OQ_CNT_W'(pop_ok);
		end
	end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the 256-bin intensity histogram.
module testbench;
	import ihist_pkg::*;

	localparam int NUM_BINS     = 256;
	localparam int COUNT_BITS   = 24;
	localparam int RANDOM_ITEMS = 550;
	localparam int HOLD_CYCLES  = 80;
	localparam int HOLD_READS   = 16;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int IN_BITS      = $bits(hist_in_t);

	typedef struct packed {
		logic                cmd;
		logic [IDX_BITS-1:0] pix;
		logic [IDX_BITS-1:0] idx;
		logic                typed;
		logic [OUT_BITS-1:0] count;
	} dir_row_t;

	localparam int DIR_ROWS  = 24;
	localparam int DIR_IDX_W = $clog2(DIR_ROWS);
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{CMD_READ,  8'h00, 8'h00, 1'b1, 24'd0},
		'{CMD_READ,  8'h00, 8'hFF, 1'b1, 24'd0},
		'{CMD_COUNT, 8'h00, 8'h00, 1'b0, 24'd0},
		'{CMD_COUNT, 8'hFF, 8'h00, 1'b0, 24'd0},
		'{CMD_COUNT, 8'hFF, 8'hFF, 1'b0, 24'd0},
		'{CMD_COUNT, 8'hFF, 8'h55, 1'b0, 24'd0},
		'{CMD_READ,  8'hFF, 8'h00, 1'b1, 24'd1},
		'{CMD_READ,  8'h00, 8'hFF, 1'b1, 24'd3},
		'{CMD_READ,  8'h00, 8'hFF, 1'b1, 24'd0},
		'{CMD_COUNT, 8'hAA, 8'h55, 1'b0, 24'd0},
		'{CMD_COUNT, 8'h55, 8'hAA, 1'b0, 24'd0},
		'{CMD_COUNT, 8'hAA, 8'h00, 1'b0, 24'd0},
		'{CMD_READ,  8'h00, 8'hAA, 1'b1, 24'd2},
		'{CMD_READ,  8'h00, 8'h55, 1'b1, 24'd1},
		'{CMD_COUNT, 8'h80, 8'h7F, 1'b0, 24'd0},
		'{CMD_READ,  8'hFF, 8'h80, 1'b1, 24'd1},
		'{CMD_COUNT, 8'h10, 8'h00, 1'b0, 24'd0},
		'{CMD_READ,  8'h00, 8'h10, 1'b0, 24'd0},
		'{CMD_COUNT, 8'h10, 8'h00, 1'b0, 24'd0},
		'{CMD_COUNT, 8'h10, 8'h00, 1'b0, 24'd0},
		'{CMD_READ,  8'h00, 8'h10, 1'b0, 24'd0},
		'{CMD_COUNT, 8'h01, 8'hFE, 1'b0, 24'd0},
		'{CMD_READ,  8'h7F, 8'h01, 1'b0, 24'd0},
		'{CMD_READ,  8'h00, 8'h7F, 1'b1, 24'd0}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      push;
	logic      full;
	hist_in_t  in_data;
	logic      empty;
	logic      pop;
	hist_out_t out_data;

	logic [COUNT_BITS-1:0] bin_model [NUM_BINS];
	hist_out_t             pending_reads [$];
	int                    mismatches = 0;
	int                    items_sent = 0;
	int                    hold_token = 0;
	int                    cycles;
	bit                    send_steady = 1'b0;

	intensity_histogram_256 i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

	always #1 clk = ~clk;

	// Updates the bin store for one request; returns 1 when a read produces a result.
	function automatic bit predict_histogram(input hist_in_t req, output hist_out_t res);
		logic [COUNT_BITS-1:0] held;
		held = '0;
		res  = '0;
		if (req.cmd == CMD_COUNT) begin
			if (int'(req.pixel_value) < NUM_BINS && bin_model[req.pixel_value] != '1)
				bin_model[req.pixel_value] = bin_model[req.pixel_value] + 1'b1;
			return 1'b0;
		end
		if (int'(req.bin_index) < NUM_BINS) begin
			held = bin_model[req.bin_index];
			bin_model[req.bin_index] = '0;
		end
		res.read_bin  = req.bin_index;
		res.bin_count = (held > COUNT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(held);
		return 1'b1;
	endfunction

	// Mostly short gaps, a few long ones, none at all during steady stretches.
	function automatic int idle_gap(input bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	task automatic send_req(input hist_in_t req, input int gap, input bit typed,
			input hist_out_t typed_res);
		hist_out_t res;
		in_data <= req;
		push    <= 1'b1;
		do @(posedge clk); while (full);
		if (predict_histogram(req, res))
			pending_reads.push_back(typed ? typed_res : res);
		items_sent++;
		if ($urandom_range(0, 39) == 0)
			send_steady = ~send_steady;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input hist_in_t req);
		send_req(req, idle_gap(send_steady), 1'b0, '0);
	endtask

	// One small image: counts on a few hot pixels plus stray pixels, then read the hot bins.
	task automatic send_image();
		logic [IDX_BITS-1:0] hot [4];
		int                  n_hot;
		int                  n_pix;
		hist_in_t            req;
		n_hot = $urandom_range(1, 4);
		n_pix = $urandom_range(3, 16);
		for (int i = 0; i < 4; i++)
			hot[2'(i)] = IDX_BITS'($urandom);
		repeat (n_pix) begin
			req.cmd         = CMD_COUNT;
			req.pixel_value = ($urandom_range(0, 3) != 0) ? hot[2'($urandom_range(0, n_hot - 1))]
				: IDX_BITS'($urandom);
			req.bin_index   = IDX_BITS'($urandom);
			send_random(req);
		end
		for (int i = 0; i < n_hot; i++) begin
			req.cmd         = CMD_READ;
			req.pixel_value = IDX_BITS'($urandom);
			req.bin_index   = hot[2'(i)];
			send_random(req);
		end
	endtask

	task automatic check_result(input hist_out_t got);
		hist_out_t want;
		if (pending_reads.size() == 0) begin
			$error("unexpected result: read_bin=%0d bin_count=%0d", got.read_bin, got.bin_count);
			mismatches++;
			return;
		end
		want = pending_reads.pop_front();
		if (got.read_bin !== want.read_bin) begin
			$error("read_bin: expected %0d, got %0d", want.read_bin, got.read_bin);
			mismatches++;
		end
		if (got.bin_count !== want.bin_count) begin
			$error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
			mismatches++;
		end
	endtask

	// Result side: random stalls, plus a long hold-off whenever the sender asks for one.
	initial begin
		int  stall;
		int  hold_seen;
		bit  pop_steady;
		stall      = 0;
		hold_seen  = 0;
		pop_steady = 1'b0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result(out_data);
			if ($urandom_range(0, 199) == 0)
				pop_steady = ~pop_steady;
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				stall     = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = idle_gap(pop_steady);
			end
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		hist_in_t             req;
		hist_out_t            typed_res;
		bit                   hold_done;
		bit                   drain_done;
		logic [DIR_IDX_W-1:0] row;
		hold_done  = 1'b0;
		drain_done = 1'b0;
		bin_model  = '{default: '0};
		arst_n  <= 1'b0;
		push    <= 1'b0;
		in_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row                 = DIR_IDX_W'(i);
			req.cmd             = DIRECTED[row].cmd;
			req.pixel_value     = DIRECTED[row].pix;
			req.bin_index       = DIRECTED[row].idx;
			typed_res.read_bin  = DIRECTED[row].idx;
			typed_res.bin_count = DIRECTED[row].count;
			send_req(req, 0, DIRECTED[row].typed, typed_res);
		end
		push <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);

		// A saturated bin needs 2^24 - 1 counts, far beyond this run, so saturation is
		// covered only by the predictor and never provoked.
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (!hold_done && items_sent > 200) begin
				// Stop reading results while reads keep coming, so the block must stall.
				hold_done = 1'b1;
				hold_token <= hold_token + 1;
				repeat (HOLD_READS) begin
					req.cmd         = CMD_READ;
					req.pixel_value = IDX_BITS'($urandom);
					req.bin_index   = IDX_BITS'($urandom);
					send_req(req, 0, 1'b0, '0);
				end
			end else if (!drain_done && items_sent > 380) begin
				drain_done = 1'b1;
				push <= 1'b0;
				while (pending_reads.size() != 0)
					@(posedge clk);
			end else if ($urandom_range(0, 9) < 7) begin
				send_image();
			end else begin
				req = IN_BITS'($urandom);
				send_random(req);
			end
		end
		push <= 1'b0;

		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
